@@ src/stereo_attenuator_serial_writer_unit_assert.svh @@
// Assertion macros for the stereo attenuator serial writer.
`ifndef STEREO_ATTENUATOR_SERIAL_WRITER_UNIT_ASSERT_SVH
`define STEREO_ATTENUATOR_SERIAL_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SASWU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("saswu check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define SASWU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("saswu sequence check failed");

`endif

@@ src/saswu_pkg.sv @@
// Shared constants, types and word coding for the stereo attenuator serial writer.
`timescale 1ns / 1ps
package saswu_pkg;

  localparam int WORD_BITS    = 18;
  localparam int MAX_LEVEL    = 68;
  localparam int LEVEL_W      = 7;
  localparam int MINOR_BASE   = 7;
  localparam int CH_LEFT_POS  = 13;
  localparam int CH_RIGHT_POS = 14;
  localparam int MAJOR_STEP   = 10;
  localparam int IDX_W        = $clog2(WORD_BITS + 1);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int VOLUME_RESET = 56;

  localparam logic signed [7:0] LEVEL_MAX_S = 8'(MAX_LEVEL);
  localparam logic signed [7:0] LEVEL_MIN_S = -LEVEL_MAX_S;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [LEVEL_W-1:0]   level_t;

  typedef struct packed {
    word_t left_word;
    word_t right_word;
    logic  we;
  } entry_t;

  typedef struct packed {
    logic serial_data;
    logic latch;
    logic channel_right;
    logic write_enable_pin;
    logic last;
  } result_t;

  function automatic word_t code_word(input level_t level, input logic right);
    level_t     att;
    logic [2:0] major;
    level_t     rem;
    logic [2:0] minor;
    word_t      w;
    att = level_t'(MAX_LEVEL) - level;
    if (att >= level_t'(6 * MAJOR_STEP)) major = 3'd6;
    else if (att >= level_t'(5 * MAJOR_STEP)) major = 3'd5;
    else if (att >= level_t'(4 * MAJOR_STEP)) major = 3'd4;
    else if (att >= level_t'(3 * MAJOR_STEP)) major = 3'd3;
    else if (att >= level_t'(2 * MAJOR_STEP)) major = 3'd2;
    else if (att >= level_t'(MAJOR_STEP)) major = 3'd1;
    else major = 3'd0;
    rem   = att - level_t'(major) * level_t'(MAJOR_STEP);
    minor = 3'(rem >> 1);
    w = (word_t'(1) << major)
      | (word_t'(1) << (4'(MINOR_BASE) + {1'b0, minor}))
      | (word_t'(1) << (right ? CH_RIGHT_POS : CH_LEFT_POS));
    return w;
  endfunction

endpackage

@@ src/stereo_attenuator_serial_writer_unit.sv @@
// Top level of the stereo attenuator serial writer.
//
//   channel   ports                                              handshake
//   input     action, setting_value, mute                        push / full
//   result    serial_data, latch, channel_right,                 pop / empty
//             write_enable_pin, last
//
// Each input word yields 38 result words, one per cycle while pop keeps up,
// so the serializer takes the next input word only as it produces the last result of the current one.
// An accepted input word passes the front-end register, the queue, the serializer and the result register.
// rst is synchronous: volume returns to 56, balance to 0, all queues empty.
// The front end and a two-entry queue keep accepting while results stall, until they fill.
`timescale 1ns / 1ps
`include "stereo_attenuator_serial_writer_unit_assert.svh"
module stereo_attenuator_serial_writer_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              action,
  input  logic signed [7:0] setting_value,
  input  logic              mute,
  output logic              empty,
  input  logic              pop,
  output logic              serial_data,
  output logic              latch,
  output logic              channel_right,
  output logic              write_enable_pin,
  output logic              last
);

  logic               f_push;
  saswu_pkg::entry_t  f_data;
  logic               q_full;
  logic               q_valid;
  saswu_pkg::entry_t  q_data;
  logic               q_pop;
  logic               res_valid;
  saswu_pkg::result_t res;

  saswu_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .action        (action),
    .setting_value (setting_value),
    .mute          (mute),
    .full          (full),
    .q_push        (f_push),
    .q_data        (f_data),
    .q_full        (q_full)
  );

  saswu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .data_in  (f_data),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .data_out (q_data)
  );

  saswu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  assign empty            = !res_valid;
  assign serial_data      = res.serial_data;
  assign latch            = res.latch;
  assign channel_right    = res.channel_right;
  assign write_enable_pin = res.write_enable_pin;
  assign last             = res.last;

  `SASWU_ASSERT_NOW(a_last_on_right_latch, !empty && last, latch && channel_right)
  `SASWU_ASSERT_NOW(a_latch_carries_no_data, !empty && latch, !serial_data)
  `SASWU_ASSERT_NEXT(a_right_follows_left, !empty && pop && latch && !channel_right, !empty && channel_right && !latch)

endmodule

@@ src/saswu_front.sv @@
// Front end: accepts setting words, keeps volume and balance, codes both channel words.
`timescale 1ns / 1ps
module saswu_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic                   action,
  input  logic signed [7:0]      setting_value,
  input  logic                   mute,
  output logic                   full,
  output logic                   q_push,
  output saswu_pkg::entry_t      q_data,
  input  logic                   q_full
);

  saswu_pkg::level_t volume_now;
  logic signed [7:0] balance_now;
  logic              pending;
  logic              we;

  logic              accept;
  saswu_pkg::level_t vol_sat;
  logic signed [7:0] bal_sat;
  logic signed [8:0] vol_s;
  logic signed [8:0] bal_s;
  logic signed [8:0] diff_l;
  logic signed [8:0] diff_r;
  saswu_pkg::level_t left_level;
  saswu_pkg::level_t right_level;

  assign full   = pending && q_full;
  assign accept = push && !full;
  assign q_push = pending && !q_full;

  always_comb begin
    if (setting_value < 8'sd0) begin
      vol_sat = '0;
    end else if (setting_value > saswu_pkg::LEVEL_MAX_S) begin
      vol_sat = saswu_pkg::level_t'(saswu_pkg::MAX_LEVEL);
    end else begin
      vol_sat = setting_value[saswu_pkg::LEVEL_W-1:0];
    end
    if (setting_value < saswu_pkg::LEVEL_MIN_S) begin
      bal_sat = saswu_pkg::LEVEL_MIN_S;
    end else if (setting_value > saswu_pkg::LEVEL_MAX_S) begin
      bal_sat = saswu_pkg::LEVEL_MAX_S;
    end else begin
      bal_sat = setting_value;
    end
  end

  always_comb begin
    vol_s  = $signed({2'b00, volume_now});
    bal_s  = $signed({balance_now[7], balance_now});
    diff_l = vol_s - bal_s;
    diff_r = vol_s + bal_s;
    left_level  = volume_now;
    right_level = volume_now;
    if (balance_now > 8'sd0) begin
      left_level = (diff_l < 9'sd0) ? '0 : diff_l[saswu_pkg::LEVEL_W-1:0];
    end
    if (balance_now < 8'sd0) begin
      right_level = (diff_r < 9'sd0) ? '0 : diff_r[saswu_pkg::LEVEL_W-1:0];
    end
    q_data.left_word  = saswu_pkg::code_word(left_level, 1'b0);
    q_data.right_word = saswu_pkg::code_word(right_level, 1'b1);
    q_data.we         = we;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_now  <= saswu_pkg::level_t'(saswu_pkg::VOLUME_RESET);
      balance_now <= '0;
      pending     <= 1'b0;
    end else begin
      if (accept) begin
        if (action) begin
          balance_now <= bal_sat;
        end else begin
          volume_now <= vol_sat;
        end
        pending <= 1'b1;
      end else if (q_push) begin
        pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      we <= !mute;
    end
  end

endmodule

@@ src/saswu_queue.sv @@
// Short queue of coded word pairs between front and back ends.
`timescale 1ns / 1ps
module saswu_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  saswu_pkg::entry_t data_in,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output saswu_pkg::entry_t data_out
);

  saswu_pkg::entry_t                  slots [saswu_pkg::QUEUE_DEPTH];
  logic [saswu_pkg::QPTR_W-1:0]       wr_ptr;
  logic [saswu_pkg::QPTR_W-1:0]       rd_ptr;
  logic [saswu_pkg::QCNT_W-1:0]       count;
  logic                               do_push;
  logic                               do_pop;

  assign full     = count == saswu_pkg::QCNT_W'(saswu_pkg::QUEUE_DEPTH);
  assign valid    = count != '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign data_out = slots[rd_ptr];

  function automatic logic [saswu_pkg::QPTR_W-1:0] bump(
    input logic [saswu_pkg::QPTR_W-1:0] p
  );
    return (p == saswu_pkg::QPTR_W'(saswu_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= data_in;
    end
  end

endmodule

@@ src/saswu_back.sv @@
// Back end: shifts out left word, latch, right word, latch into the result register.
`timescale 1ns / 1ps
module saswu_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  saswu_pkg::entry_t  q_data,
  output logic               q_pop,
  output logic               res_valid,
  output saswu_pkg::result_t res,
  input  logic               res_pop
);

  logic                          busy;
  logic                          side;
  logic [saswu_pkg::IDX_W-1:0]   idx;
  saswu_pkg::word_t              sr;
  saswu_pkg::word_t              right_word;
  logic                          we;
  logic                          out_valid;
  saswu_pkg::result_t            out;

  logic advance;
  logic produce;
  logic at_latch;
  logic at_last;
  logic load;

  assign advance  = !out_valid || res_pop;
  assign produce  = advance && busy;
  assign at_latch = idx == saswu_pkg::IDX_W'(saswu_pkg::WORD_BITS);
  assign at_last  = at_latch && side;
  assign load     = q_valid && (!busy || (produce && at_last));
  assign q_pop    = load;

  assign res_valid = out_valid;
  assign res       = out;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      side      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= busy;
      end
      if (load) begin
        busy <= 1'b1;
        side <= 1'b0;
        idx  <= '0;
      end else if (produce) begin
        if (at_latch) begin
          idx <= '0;
          if (side) begin
            busy <= 1'b0;
          end else begin
            side <= 1'b1;
          end
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out.serial_data      <= at_latch ? 1'b0 : sr[0];
      out.latch            <= at_latch;
      out.channel_right    <= side;
      out.write_enable_pin <= we;
      out.last             <= at_last;
    end
    if (load) begin
      sr         <= q_data.left_word;
      right_word <= q_data.right_word;
      we         <= q_data.we;
    end else if (produce) begin
      sr <= (at_latch && !side) ? right_word : (sr >> 1);
    end
  end

endmodule
